// ===== hw/rtl/lca_pkg.sv =====
package lca_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int COL_W       = $clog2(GRID_WIDTH);
    localparam int ROW_W       = $clog2(GRID_HEIGHT);
    localparam int MODE_W      = 2;
    localparam int COORD_W     = 6;

    typedef logic [GRID_WIDTH-1:0] t_row;
    typedef logic [COL_W-1:0]      t_col_idx;
    typedef logic [ROW_W-1:0]      t_row_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET  = 2'd0,
        MODE_STEP = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH
    } t_state;

endpackage

// ===== hw/rtl/lca_row_cell.sv =====
module lca_row_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  lca_pkg::t_row i_row,
    output lca_pkg::t_row o_row
);
    import lca_pkg::*;

    t_row r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_shift) begin
            r_row <= i_row;
        end
    end

    assign o_row = r_row;

endmodule

// ===== hw/rtl/lca_rule.sv =====
module lca_rule (
    input  lca_pkg::t_row i_above,
    input  lca_pkg::t_row i_cur,
    input  lca_pkg::t_row i_below,
    output lca_pkg::t_row o_next
);
    import lca_pkg::*;

    logic [GRID_WIDTH+1:0] w_a;
    logic [GRID_WIDTH+1:0] w_c;
    logic [GRID_WIDTH+1:0] w_b;

    assign w_a = {1'b0, i_above, 1'b0};
    assign w_c = {1'b0, i_cur, 1'b0};
    assign w_b = {1'b0, i_below, 1'b0};

    // padded index c+1 is column c
    always_comb begin
        logic [3:0] n;
        for (int c = 0; c < GRID_WIDTH; c++) begin
            n = 4'(w_a[c]) + 4'(w_a[c+1]) + 4'(w_a[c+2])
              + 4'(w_c[c]) + 4'(w_c[c+2])
              + 4'(w_b[c]) + 4'(w_b[c+1]) + 4'(w_b[c+2]);
            o_next[c] = (n == 4'd3) || (i_cur[c] && (n == 4'd2));
        end
    end

endmodule

// ===== hw/rtl/life_cellular_automaton.sv =====
// channel   | valid       | ready       | payload
// ----------+-------------+-------------+----------------------------------
// request   | i_in_valid  | o_in_ready  | i_mode, i_cell_x, i_cell_y
// response  | o_out_valid | i_out_ready | o_cell_alive, o_in_range
//
// Every transaction rotates the row chain once through all GRID_HEIGHT rows,
// then returns to idle. The generation, set and read all act on the
// row at the head of the chain as it passes.
// Reset clears every cell to dead directly; no clearing pass.
// A held response does not block the next request; a second response
// waits at the end of its sweep until the output register is free.
module life_cellular_automaton (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lca_pkg::MODE_W-1:0]   i_mode,
    input  logic [lca_pkg::COORD_W-1:0]  i_cell_x,
    input  logic [lca_pkg::COORD_W-1:0]  i_cell_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_cell_alive,
    output logic                         o_in_range
);
    import lca_pkg::*;

    localparam t_row_idx LAST_ROW = ROW_W'(GRID_HEIGHT - 1);

    t_state   r_state, n_state;
    t_row_idx r_cnt, n_cnt;
    t_mode    r_mode;
    t_col_idx r_col;
    t_row_idx r_row_sel;
    logic     r_xy_ok;
    logic     r_bit;
    t_row     r_prev;
    logic     r_out_valid, n_out_valid;
    logic     r_out_alive, r_out_range;

    t_row     w_rows [GRID_HEIGHT];
    t_row     w_tail;
    t_row     w_next;
    t_row     w_above;
    t_row     w_below;
    t_row     w_set_mask;
    logic     w_shift;
    logic     w_accept;
    logic     w_hit_row;
    logic     w_bit;
    logic     w_load_out;
    logic     w_res_alive;
    logic     w_res_range;

    genvar g;
    generate
        for (g = 0; g < GRID_HEIGHT; g++) begin : g_chain
            if (g == GRID_HEIGHT - 1) begin : g_tail
                lca_row_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_row   (w_tail),
                    .o_row   (w_rows[g])
                );
            end else begin : g_body
                lca_row_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_row   (w_rows[g+1]),
                    .o_row   (w_rows[g])
                );
            end
        end
    endgenerate

    assign w_above = (r_cnt == '0) ? '0 : r_prev;
    assign w_below = (r_cnt == LAST_ROW) ? '0 : w_rows[1];

    lca_rule u_rule (
        .i_above (w_above),
        .i_cur   (w_rows[0]),
        .i_below (w_below),
        .o_next  (w_next)
    );

    assign w_hit_row  = r_xy_ok && (r_cnt == r_row_sel);
    assign w_set_mask = (r_mode == MODE_SET && w_hit_row) ? (t_row'(1) << r_col) : '0;
    assign w_tail     = (r_mode == MODE_STEP) ? w_next : (w_rows[0] | w_set_mask);
    assign w_shift    = (r_state == ST_SWEEP);

    // last row read straight off the head, as the response loads on that edge
    assign w_bit      = (w_shift && w_hit_row) ? w_rows[0][r_col] : r_bit;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_mode)
            MODE_SET: begin
                w_res_alive = r_xy_ok;
                w_res_range = r_xy_ok;
            end
            MODE_STEP: begin
                w_res_alive = 1'b0;
                w_res_range = 1'b1;
            end
            MODE_READ: begin
                w_res_alive = r_xy_ok && w_bit;
                w_res_range = r_xy_ok;
            end
            default: begin
                w_res_alive = 1'b0;
                w_res_range = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        w_load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_cnt == LAST_ROW) begin
                    n_cnt = '0;
                    if (r_out_valid && !i_out_ready) begin
                        n_state = ST_FLUSH;
                    end else begin
                        w_load_out  = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode    <= t_mode'(i_mode);
            r_col     <= COL_W'(i_cell_x);
            r_row_sel <= ROW_W'(i_cell_y);
            r_xy_ok   <= (32'(i_cell_x) < 32'(GRID_WIDTH))
                      && (32'(i_cell_y) < 32'(GRID_HEIGHT));
        end
        if (w_shift) begin
            r_prev <= w_rows[0];
            if (w_hit_row) begin
                r_bit <= w_rows[0][r_col];
            end
        end
        if (w_load_out) begin
            r_out_alive <= w_res_alive;
            r_out_range <= w_res_range;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_alive = r_out_alive;
    assign o_in_range   = r_out_range;

    a_sweep_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && r_cnt != LAST_ROW) |=> (r_state == ST_SWEEP))
        else $error("sweep left early");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SWEEP && r_cnt == '0))
        else $error("transaction did not start a sweep at row zero");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SWEEP) |-> (r_cnt == '0))
        else $error("row counter running outside sweep");

    a_resp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_SWEEP || $past(r_state) == ST_FLUSH))
        else $error("response raised without a finished sweep");

endmodule

// ===== tb/life_cellular_automaton_tb.sv =====
`timescale 1ns / 100ps

module life_cellular_automaton_tb;

    import lca_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 217;
    localparam int DIR_ROWS    = 25;

    typedef struct {
        logic alive;
        logic in_range;
    } t_cell_reply;

    typedef struct packed {
        t_mode              mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               fixed;
        logic               alive;
        logic               in_range;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [MODE_W-1:0]  i_mode;
    logic [COORD_W-1:0] i_cell_x;
    logic [COORD_W-1:0] i_cell_y;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_cell_alive;
    logic               o_in_range;

    t_row        life_rows [GRID_HEIGHT];
    t_cell_reply cell_replies_due [$];
    int          error_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          holds_requested;
    int          holds_served;
    int          hold_left;
    int          quiet_cycles;

    // corners, a blinker through two generations, a corner block
    t_dir_row dir_table [DIR_ROWS] = '{
        '{MODE_READ, 6'd0,  6'd0,  1'b1, 1'b0, 1'b1},
        '{MODE_READ, 6'd63, 6'd63, 1'b1, 1'b0, 1'b1},
        '{MODE_NOP,  6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
        '{MODE_SET,  6'd0,  6'd0,  1'b1, 1'b1, 1'b1},
        '{MODE_SET,  6'd63, 6'd63, 1'b1, 1'b1, 1'b1},
        '{MODE_SET,  6'd63, 6'd0,  1'b1, 1'b1, 1'b1},
        '{MODE_SET,  6'd0,  6'd63, 1'b1, 1'b1, 1'b1},
        '{MODE_READ, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{MODE_STEP, 6'd21, 6'd42, 1'b1, 1'b0, 1'b1},
        '{MODE_READ, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{MODE_SET,  6'd10, 6'd20, 1'b1, 1'b1, 1'b1},
        '{MODE_SET,  6'd11, 6'd20, 1'b1, 1'b1, 1'b1},
        '{MODE_SET,  6'd12, 6'd20, 1'b1, 1'b1, 1'b1},
        '{MODE_STEP, 6'd0,  6'd0,  1'b1, 1'b0, 1'b1},
        '{MODE_READ, 6'd11, 6'd19, 1'b0, 1'b0, 1'b0},
        '{MODE_READ, 6'd11, 6'd21, 1'b0, 1'b0, 1'b0},
        '{MODE_READ, 6'd10, 6'd20, 1'b0, 1'b0, 1'b0},
        '{MODE_STEP, 6'd63, 6'd63, 1'b1, 1'b0, 1'b1},
        '{MODE_READ, 6'd10, 6'd20, 1'b0, 1'b0, 1'b0},
        '{MODE_SET,  6'd62, 6'd62, 1'b1, 1'b1, 1'b1},
        '{MODE_SET,  6'd63, 6'd62, 1'b1, 1'b1, 1'b1},
        '{MODE_SET,  6'd62, 6'd63, 1'b1, 1'b1, 1'b1},
        '{MODE_STEP, 6'd5,  6'd50, 1'b1, 1'b0, 1'b1},
        '{MODE_READ, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{MODE_NOP,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0}
    };

    life_cellular_automaton i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_alive (o_cell_alive),
        .o_in_range   (o_in_range)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void life_generation();
        t_row nxt [GRID_HEIGHT];
        int   n;
        for (int r = 0; r < GRID_HEIGHT; r++) begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_HEIGHT
                            && c + dc >= 0 && c + dc < GRID_WIDTH) begin
                            n += int'(life_rows[r + dr][c + dc]);
                        end
                    end
                end
                nxt[r][c] = (n == 3) || (life_rows[r][c] && n == 2);
            end
        end
        life_rows = nxt;
    endfunction

    function automatic void life_apply(input t_mode m, input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       output logic alive, output logic in_range);
        logic on_grid;
        on_grid  = (int'(x) < GRID_WIDTH) && (int'(y) < GRID_HEIGHT);
        alive    = 1'b0;
        in_range = 1'b0;
        case (m)
            MODE_SET: begin
                if (on_grid) begin
                    life_rows[y][x] = 1'b1;
                    alive    = 1'b1;
                    in_range = 1'b1;
                end
            end
            MODE_STEP: begin
                life_generation();
                in_range = 1'b1;
            end
            MODE_READ: begin
                if (on_grid) begin
                    alive    = life_rows[y][x];
                    in_range = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic want, input logic got);
        $display("%0t: mismatch on %s: expected %b, got %b", $time, what, want, got);
        error_count++;
    endtask

    task automatic offer_cell_op(input t_mode m, input logic [COORD_W-1:0] x,
                                 input logic [COORD_W-1:0] y, input logic fixed,
                                 input logic fx_alive, input logic fx_range);
        t_cell_reply want;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_cell_x   <= x;
        i_cell_y   <= y;
        do @(posedge i_clk); while (!o_in_ready);
        life_apply(m, x, y, want.alive, want.in_range);
        if (fixed) begin
            want.alive    = fx_alive;
            want.in_range = fx_range;
        end
        cell_replies_due.push_back(want);
    endtask

    // response side: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        if (holds_served != holds_requested) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cell_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cell_replies_due.size() == 0) begin
                report_mismatch("unexpected transaction", 1'b0, 1'b1);
            end else begin
                want = cell_replies_due.pop_front();
                if (o_cell_alive !== want.alive) begin
                    report_mismatch("cell_alive", want.alive, o_cell_alive);
                end
                if (o_in_range !== want.in_range) begin
                    report_mismatch("in_range", want.in_range, o_in_range);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("life_cellular_automaton_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_mode              m;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] focus_x;
        logic [COORD_W-1:0] focus_y;
        int                 r;

        error_count     = 0;
        holds_requested = 0;
        holds_served    = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        tx_idle_pct     = 23;
        rx_idle_pct     = 86;
        for (int i = 0; i < GRID_HEIGHT; i++) begin
            life_rows[i] = '0;
        end
        focus_x = 6'd20;
        focus_y = 6'd20;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode      <= MODE_NOP;
        i_cell_x    <= '0;
        i_cell_y    <= '0;
        i_out_ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            offer_cell_op(dir_table[i].mode, dir_table[i].x, dir_table[i].y,
                          dir_table[i].fixed, dir_table[i].alive, dir_table[i].in_range);
        end

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                tx_idle_pct = 86;
                rx_idle_pct = 23;
            end else if (phase == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                holds_requested++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(39) == 0) begin
                    r = $urandom_range(3);
                    focus_x = (r == 0) ? 6'd0 : (r == 1) ? 6'd56 : 6'($urandom_range(63));
                    r = $urandom_range(3);
                    focus_y = (r == 0) ? 6'd0 : (r == 1) ? 6'd56 : 6'($urandom_range(63));
                end
                x = focus_x + 6'($urandom_range(7));
                y = focus_y + 6'($urandom_range(7));
                r = $urandom_range(99);
                if (r < 8) begin
                    m = MODE_NOP;
                    x = 6'($urandom_range(63));
                    y = 6'($urandom_range(63));
                end else if (r < 20) begin
                    m = MODE_STEP;
                    x = 6'($urandom_range(63));
                    y = 6'($urandom_range(63));
                end else if (r < 55) begin
                    m = MODE_SET;
                end else begin
                    m = MODE_READ;
                    if ($urandom_range(4) == 0) begin
                        x = 6'($urandom_range(63));
                        y = 6'($urandom_range(63));
                    end
                end
                offer_cell_op(m, x, y, 1'b0, 1'b0, 1'b0);
            end
        end
        i_in_valid <= 1'b0;

        while (cell_replies_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
        if (error_count == 0) begin
            $display("life_cellular_automaton_tb: done, clean");
        end else begin
            $display("life_cellular_automaton_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lca_pkg.sv
hw/rtl/lca_row_cell.sv
hw/rtl/lca_rule.sv
hw/rtl/life_cellular_automaton.sv
tb/life_cellular_automaton_tb.sv
